@@ src/ei_input_shaper_seven_channel_core_assert.svh @@
// Assertion macros for the input shaper core
`ifndef EI_INPUT_SHAPER_SEVEN_CHANNEL_CORE_ASSERT_SVH
`define EI_INPUT_SHAPER_SEVEN_CHANNEL_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define EIS_ASSERT_IMPLY(name, clk, rst, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("implication check failed");
`define EIS_ASSERT_NEXT(name, clk, rst, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("next-cycle check failed");
`else
`define EIS_ASSERT_IMPLY(name, clk, rst, pre, post)
`define EIS_ASSERT_NEXT(name, clk, rst, pre, post)
`endif
`endif

@@ src/eis_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package eis_pkg;
  localparam int NumPos          = 7;
  localparam int PosW            = 16;
  localparam int DelayW          = 7;
  localparam int FracW           = 16;
  localparam int GainW           = 17;
  localparam int CfgIdxW         = 3;
  localparam int CfgDataW        = 17;
  localparam int DefHistoryDepth = 128;
  localparam int DefChannels     = 7;
  localparam int ChW             = 3;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PRIME,
    S_WRITE,
    S_REDUCE,
    S_READ,
    S_CALC,
    S_DONE
  } state_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DELAY_MID  = 3'd0,
    REG_DELAY_LATE = 3'd1,
    REG_FRAC_MID   = 3'd2,
    REG_FRAC_LATE  = 3'd3,
    REG_GAIN_FIRST = 3'd4,
    REG_GAIN_MID   = 3'd5,
    REG_GAIN_LATE  = 3'd6,
    REG_NONE       = 3'd7
  } reg_idx_t;

  typedef enum logic {
    OP_SHAPE = 1'b0,
    OP_PRIME = 1'b1
  } op_t;

  typedef struct packed {
    logic            op;
    logic [PosW-1:0] position_0;
    logic [PosW-1:0] position_1;
    logic [PosW-1:0] position_2;
    logic [PosW-1:0] position_3;
    logic [PosW-1:0] position_4;
    logic [PosW-1:0] position_5;
    logic [PosW-1:0] position_6;
  } in_beat_t;

  typedef struct packed {
    logic [PosW-1:0] shaped_0;
    logic [PosW-1:0] shaped_1;
    logic [PosW-1:0] shaped_2;
    logic [PosW-1:0] shaped_3;
    logic [PosW-1:0] shaped_4;
    logic [PosW-1:0] shaped_5;
    logic [PosW-1:0] shaped_6;
  } out_beat_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] value;
  } cfg_beat_t;
endpackage
`default_nettype wire

@@ src/eis_stream_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface eis_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ src/ei_input_shaper_seven_channel_core.sv @@
// Three-impulse EI input shaper over up to seven 16-bit channels. After reset the
// history ring of HISTORY_DEPTH rows (128 by default) is cleared before the first
// sample beat is taken; a prime beat refills every row of the ring and gives no
// result. A shape beat goes through one row write, one delay check plus one wrap
// pass for each HISTORY_DEPTH that a delay reaches (none for 7-bit delays at the
// default depth), reads of the current row and the four delayed tap rows from the
// history memory (one read port, one write port), eight passes through the one
// shared 32x17 multiplier for each channel, and a load of the result register.
// That load is held off while an earlier result still waits on the result channel.
// The next beat is taken back in idle, in the cycle after the load; no new beat is
// taken before the last one is done, but the previous result may still wait on the
// result channel. Configuration writes are taken at any time but must be issued
// while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
`include "ei_input_shaper_seven_channel_core_assert.svh"
module ei_input_shaper_seven_channel_core
  import eis_pkg::*;
#(
  parameter int HISTORY_DEPTH = DefHistoryDepth,
  parameter int CHANNELS      = DefChannels
) (
  input  wire logic    clk,
  input  wire logic    rst,
  eis_stream_if.sink   sample,
  eis_stream_if.source result,
  eis_stream_if.sink   cfg
);
  localparam int AW    = $clog2(HISTORY_DEPTH);
  localparam int RW    = (AW + 1 > DelayW) ? AW + 1 : DelayW;
  localparam int RowW  = CHANNELS * PosW;
  localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int NTaps = 5;
  localparam int MaW   = 32;
  localparam int PrW   = MaW + GainW;
  localparam int AccW  = PrW + 2;

  state_t state, state_next;

  logic [DelayW-1:0] delay_mid, delay_late;
  logic [FracW-1:0]  frac_mid, frac_late;
  logic [GainW-1:0]  gain_first, gain_mid, gain_late;

  logic [RowW-1:0] mem [HISTORY_DEPTH];
  logic [RowW-1:0] rd_data;
  logic [AW-1:0]   rd_addr, wr_addr;
  logic [RowW-1:0] wr_data;
  logic            wr_en;

  logic [AW-1:0]   cursor, cursor_inc;
  logic [AW-1:0]   sweep;
  logic [RowW-1:0] in_row, row_q;
  logic            op_q;
  logic [RW-1:0]   red_mid, red_late;
  logic [2:0]      rcnt;
  logic [RowW-1:0] tap_row [NTaps];
  logic [2:0]      step;
  logic [CW-1:0]   ch;

  logic [MaW-1:0]   ma;
  logic [GainW-1:0] mb;
  logic [PrW-1:0]   prod;
  logic [31:0]      t_mid, t_late;
  logic [AccW-1:0]  acc, acc_final;
  logic [PosW-1:0]  res [NumPos];
  logic [PosW-1:0]  sat_val;

  logic      out_valid;
  out_beat_t out_data;

  logic [PosW-1:0] pos_in [NumPos];
  logic [AW:0]     off, addr_sum;
  logic [AW:0]     mid_inc, late_inc;
  logic [PosW-1:0] sa, sb, sc, sd, sx;
  logic [GainW-1:0] cf_mid, cf_late;
  logic            s_acc, r_acc;

  assign sample.ready = (state == S_IDLE);
  assign cfg.ready    = 1'b1;
  assign s_acc        = sample.valid && sample.ready;
  assign r_acc        = result.valid && result.ready;
  assign result.valid = out_valid;
  assign result.data  = out_data;

  always_comb begin
    pos_in[0] = sample.data.position_0;
    pos_in[1] = sample.data.position_1;
    pos_in[2] = sample.data.position_2;
    pos_in[3] = sample.data.position_3;
    pos_in[4] = sample.data.position_4;
    pos_in[5] = sample.data.position_5;
    pos_in[6] = sample.data.position_6;
    for (int k = 0; k < CHANNELS; k++) begin
      in_row[k*PosW +: PosW] = pos_in[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_mid  <= DelayW'(1);
      delay_late <= DelayW'(2);
      frac_mid   <= '0;
      frac_late  <= '0;
      gain_first <= GainW'(16384);
      gain_mid   <= GainW'(32768);
      gain_late  <= GainW'(16384);
    end else if (cfg.valid && cfg.ready) begin
      case (reg_idx_t'(cfg.data.idx))
        REG_DELAY_MID:  delay_mid  <= cfg.data.value[DelayW-1:0];
        REG_DELAY_LATE: delay_late <= cfg.data.value[DelayW-1:0];
        REG_FRAC_MID:   frac_mid   <= cfg.data.value[FracW-1:0];
        REG_FRAC_LATE:  frac_late  <= cfg.data.value[FracW-1:0];
        REG_GAIN_FIRST: gain_first <= cfg.data.value[GainW-1:0];
        REG_GAIN_MID:   gain_mid   <= cfg.data.value[GainW-1:0];
        REG_GAIN_LATE:  gain_late  <= cfg.data.value[GainW-1:0];
        default: ;
      endcase
    end
  end

  assign cursor_inc = (cursor == AW'(HISTORY_DEPTH - 1)) ? '0 : cursor + 1'b1;
  assign mid_inc    = {1'b0, red_mid[AW-1:0]} + 1'b1;
  assign late_inc   = {1'b0, red_late[AW-1:0]} + 1'b1;

  always_comb begin
    case (rcnt)
      3'd1:    off = {1'b0, red_mid[AW-1:0]};
      3'd2:    off = (mid_inc == (AW+1)'(HISTORY_DEPTH)) ? '0 : mid_inc;
      3'd3:    off = {1'b0, red_late[AW-1:0]};
      3'd4:    off = (late_inc == (AW+1)'(HISTORY_DEPTH)) ? '0 : late_inc;
      default: off = '0;
    endcase
    addr_sum = {1'b0, cursor} + (AW+1)'(HISTORY_DEPTH) - off;
    if (addr_sum >= (AW+1)'(HISTORY_DEPTH)) begin
      addr_sum = addr_sum - (AW+1)'(HISTORY_DEPTH);
    end
    rd_addr = addr_sum[AW-1:0];
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = sweep;
    wr_data = row_q;
    case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_data = '0;
      end
      S_PRIME: wr_en = 1'b1;
      S_WRITE: begin
        wr_en   = 1'b1;
        wr_addr = cursor_inc;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    sx      = tap_row[0][ch*PosW +: PosW];
    sa      = tap_row[1][ch*PosW +: PosW];
    sb      = tap_row[2][ch*PosW +: PosW];
    sc      = tap_row[3][ch*PosW +: PosW];
    sd      = tap_row[4][ch*PosW +: PosW];
    cf_mid  = GainW'(65536) - {1'b0, frac_mid};
    cf_late = GainW'(65536) - {1'b0, frac_late};
    case (step)
      3'd0: begin ma = MaW'(sa); mb = cf_mid; end
      3'd1: begin ma = MaW'(sb); mb = {1'b0, frac_mid}; end
      3'd2: begin ma = MaW'(sc); mb = cf_late; end
      3'd3: begin ma = MaW'(sd); mb = {1'b0, frac_late}; end
      3'd4: begin ma = t_mid; mb = gain_mid; end
      3'd5: begin ma = t_late; mb = gain_late; end
      3'd6: begin ma = MaW'(sx); mb = gain_first; end
      default: begin ma = '0; mb = '0; end
    endcase
    acc_final = acc + {prod[AccW-PosW-1:0], {PosW{1'b0}}};
    sat_val   = (acc_final[AccW-1:32] > (AccW-32)'(16'hFFFF)) ? 16'hFFFF
                                                                : acc_final[47:32];
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:  if (sweep == AW'(HISTORY_DEPTH - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (s_acc) begin
          state_next = (op_t'(sample.data.op) == OP_PRIME) ? S_PRIME : S_WRITE;
        end
      end
      S_PRIME:  if (sweep == AW'(HISTORY_DEPTH - 1)) state_next = S_IDLE;
      S_WRITE:  state_next = S_REDUCE;
      S_REDUCE: begin
        if (red_mid < RW'(HISTORY_DEPTH) && red_late < RW'(HISTORY_DEPTH)) begin
          state_next = S_READ;
        end
      end
      S_READ:   if (rcnt == 3'(NTaps)) state_next = S_CALC;
      S_CALC:   if (step == 3'd7 && ch == CW'(CHANNELS - 1)) state_next = S_DONE;
      S_DONE:   if (!out_valid || r_acc) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor    <= '0;
      sweep     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_CLEAR || state == S_PRIME) begin
        sweep <= (sweep == AW'(HISTORY_DEPTH - 1)) ? '0 : sweep + 1'b1;
      end
      if (state == S_WRITE) begin
        cursor <= cursor_inc;
      end
      if (state == S_DONE && (!out_valid || r_acc)) begin
        out_valid <= 1'b1;
      end else if (r_acc) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
    case (state)
      S_IDLE: begin
        if (s_acc) begin
          row_q <= in_row;
          op_q  <= sample.data.op;
        end
      end
      S_WRITE: begin
        red_mid  <= RW'(delay_mid);
        red_late <= RW'(delay_late);
        rcnt     <= '0;
        for (int k = 0; k < NumPos; k++) begin
          res[k] <= '0;
        end
      end
      S_REDUCE: begin
        if (red_mid >= RW'(HISTORY_DEPTH)) red_mid <= red_mid - RW'(HISTORY_DEPTH);
        if (red_late >= RW'(HISTORY_DEPTH)) red_late <= red_late - RW'(HISTORY_DEPTH);
      end
      S_READ: begin
        if (rcnt != '0) begin
          tap_row[rcnt - 1'b1] <= rd_data;
        end
        rcnt <= rcnt + 1'b1;
        step <= '0;
        ch   <= '0;
      end
      S_CALC: begin
        case (step)
          3'd1: t_mid  <= prod[31:0];
          3'd2: t_mid  <= t_mid + prod[31:0];
          3'd3: t_late <= prod[31:0];
          3'd4: t_late <= t_late + prod[31:0];
          3'd5: acc    <= AccW'(prod);
          3'd6: acc    <= acc + AccW'(prod);
          3'd7: begin
            res[ch] <= sat_val;
            ch      <= ch + 1'b1;
          end
          default: ;
        endcase
        step <= step + 1'b1;
      end
      S_DONE: begin
        if (!out_valid || r_acc) begin
          out_data.shaped_0 <= res[0];
          out_data.shaped_1 <= res[1];
          out_data.shaped_2 <= res[2];
          out_data.shaped_3 <= res[3];
          out_data.shaped_4 <= res[4];
          out_data.shaped_5 <= res[5];
          out_data.shaped_6 <= res[6];
        end
      end
      default: ;
    endcase
  end

  `EIS_ASSERT_NEXT(a_busy_after_beat, clk, rst, s_acc, !sample.ready)
  `EIS_ASSERT_NEXT(a_cursor_hold, clk, rst, state != S_WRITE, $stable(cursor))
  `EIS_ASSERT_IMPLY(a_prime_no_result, clk, rst, state == S_PRIME, op_q == OP_PRIME)
  `EIS_ASSERT_NEXT(a_calc_done, clk, rst,
                   state == S_CALC && step == 3'd7 && ch == CW'(CHANNELS - 1),
                   state == S_DONE)
endmodule
`default_nettype wire
